[rtl/modular_exponentiation_unit_macros.svh]
// Assertion macros shared by the modular exponentiation checker.
`ifndef MODULAR_EXPONENTIATION_UNIT_MACROS_SVH
`define MODULAR_EXPONENTIATION_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define MEU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define MEU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[rtl/mexp_pkg.sv]
// Package: modulus constants and sequencer state type for the modular exponentiation unit.
package mexp_pkg;

    // Prime modulus 1e9 + 7
    localparam logic [29:0] PrimeMod = 30'd1000000007;

    // Barrett constant floor(2^60 / PrimeMod)
    localparam logic [30:0] BarrettMu = 31'd1152921496;

    // Sequencer states: one modular product is MUL, QEST, QMUL, FIX
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_QEST,
        ST_QMUL,
        ST_FIX,
        ST_DONE
    } t_state;

endpackage

[rtl/modular_exponentiation_unit.sv]
// Top level: square-and-multiply modular exponentiation modulo 1e9 + 7.
//
// Computes base^exponent mod 1000000007, scanning the low EXP_BITS bits of the
// exponent from the top down (a zero exponent gives 1). Every modular product
// runs through one shared 31x31 multiplier, used three times (the product and
// two Barrett reduction steps) and followed by a subtract-and-correct step; a
// product passes through the MUL, QEST, QMUL and FIX states. Each exponent bit
// costs one squaring, plus one multiply by the base when the bit is set.
// The input side is not ready while an item is in progress. A finished result
// sits in an output register, and the next item is accepted while it waits.
module modular_exponentiation_unit
    import mexp_pkg::*;
#(
    parameter int EXP_BITS = 63
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [95:0] i_s_tdata,   // [29:0] base, [92:30] exponent, [95:93] zero
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata    // [29:0] power, [31:30] zero
);

    localparam int CntW = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;
    localparam logic [CntW-1:0] LastBit = CntW'(EXP_BITS - 1);
    localparam logic [31:0] PrimeMod32 = {2'b00, PrimeMod};
    localparam logic [31:0] PrimeMod2x = {1'b0, PrimeMod, 1'b0};

    // Control registers
    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // Payload registers
    logic                r_is_sq, n_is_sq;
    logic [CntW-1:0]     r_cnt, n_cnt;
    logic [EXP_BITS-1:0] r_exp, n_exp;
    logic [29:0]         r_base, n_base;
    logic [29:0]         r_acc, n_acc;
    logic [61:0]         r_prod, n_prod;
    logic [31:0]         r_xlo, n_xlo;
    logic [29:0]         r_power, n_power;

    logic        w_accept;
    logic        w_out_take;
    logic        w_do_mul;
    logic [29:0] w_base_in;
    logic [29:0] w_base_red;
    logic [63:0] w_exp_wide;
    logic [30:0] w_op_a;
    logic [30:0] w_op_b;
    logic [61:0] w_mult;
    logic [31:0] w_rem;
    logic [31:0] w_rem1;
    logic [31:0] w_rem2;
    logic [29:0] w_fix;

    assign o_s_tready = (r_state == ST_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_take = r_out_valid && i_m_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_power};

    // Input unpacking: base reduced below the modulus, exponent masked to EXP_BITS
    assign w_base_in  = i_s_tdata[29:0];
    assign w_base_red = (w_base_in >= PrimeMod) ? (w_base_in - PrimeMod) : w_base_in;
    assign w_exp_wide = {1'b0, i_s_tdata[92:30]};

    // Set bit pending multiply after the current squaring
    assign w_do_mul = r_is_sq && r_exp[EXP_BITS-1];

    // Shared multiplier operand select
    always_comb begin
        case (r_state)
            ST_MUL: begin
                w_op_a = {1'b0, r_acc};
                w_op_b = r_is_sq ? {1'b0, r_acc} : {1'b0, r_base};
            end
            ST_QEST: begin
                w_op_a = r_prod[59:29];
                w_op_b = BarrettMu;
            end
            ST_QMUL: begin
                w_op_a = r_prod[61:31];
                w_op_b = {1'b0, PrimeMod};
            end
            default: begin
                w_op_a = '0;
                w_op_b = '0;
            end
        endcase
    end

    assign w_mult = 62'(w_op_a) * 62'(w_op_b);

    // Barrett remainder is below 3p; fold it back below p
    assign w_rem  = r_xlo - r_prod[31:0];
    assign w_rem1 = w_rem - PrimeMod32;
    assign w_rem2 = w_rem - PrimeMod2x;
    always_comb begin
        if (w_rem >= PrimeMod2x) begin
            w_fix = w_rem2[29:0];
        end else if (w_rem >= PrimeMod32) begin
            w_fix = w_rem1[29:0];
        end else begin
            w_fix = w_rem[29:0];
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) n_state = ST_MUL;
            end
            ST_MUL:  n_state = ST_QEST;
            ST_QEST: n_state = ST_QMUL;
            ST_QMUL: n_state = ST_FIX;
            ST_FIX: begin
                if (w_do_mul) begin
                    n_state = ST_MUL;
                end else if (r_cnt == '0) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_MUL;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_m_tready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath and output register updates
    always_comb begin
        n_out_valid = r_out_valid && !w_out_take;
        n_is_sq     = r_is_sq;
        n_cnt       = r_cnt;
        n_exp       = r_exp;
        n_base      = r_base;
        n_acc       = r_acc;
        n_prod      = r_prod;
        n_xlo       = r_xlo;
        n_power     = r_power;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_acc   = 30'd1;
                    n_base  = w_base_red;
                    n_exp   = w_exp_wide[EXP_BITS-1:0];
                    n_cnt   = LastBit;
                    n_is_sq = 1'b1;
                end
            end
            ST_MUL: begin
                n_prod = w_mult;
            end
            ST_QEST: begin
                n_xlo  = r_prod[31:0];
                n_prod = w_mult;
            end
            ST_QMUL: begin
                n_prod = w_mult;
            end
            ST_FIX: begin
                n_acc = w_fix;
                if (w_do_mul) begin
                    n_is_sq = 1'b0;
                end else begin
                    n_is_sq = 1'b1;
                    n_exp   = r_exp << 1;
                    n_cnt   = r_cnt - 1'b1;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_power     = r_acc;
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_is_sq <= n_is_sq;
        r_cnt   <= n_cnt;
        r_exp   <= n_exp;
        r_base  <= n_base;
        r_acc   <= n_acc;
        r_prod  <= n_prod;
        r_xlo   <= n_xlo;
        r_power <= n_power;
    end

endmodule

[rtl/mexp_checker.sv]
// Port-level checker for the modular exponentiation unit, with its bind.
`include "modular_exponentiation_unit_macros.svh"

module mexp_checker
    import mexp_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [95:0] i_s_tdata,   // [29:0] base, [92:30] exponent, [95:93] zero
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata    // [29:0] power, [31:30] zero
);

    // Stalled result holds
    `MEU_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata), "result dropped or changed while stalled")

    // Result is a residue with clean padding
    `MEU_ASSERT_NOW(a_out_range, o_m_tvalid, (o_m_tdata[29:0] < PrimeMod) && (o_m_tdata[31:30] == 2'b00), "result not reduced below the modulus")

    // Block is busy right after taking an item
    `MEU_ASSERT_NEXT(a_busy_after_accept, i_s_tvalid && o_s_tready, !o_s_tready, "ready stayed high after an item was taken")

    // A result never rises in the cycle after an item is taken
    `MEU_ASSERT_NEXT(a_no_instant_result, i_s_tvalid && o_s_tready, !$rose(o_m_tvalid), "result raised too early after an item")

endmodule

bind modular_exponentiation_unit mexp_checker u_mexp_checker (.*);

[verif/modular_exponentiation_unit_tb.sv]
// Testbench for the modular exponentiation unit: stream driver, monitor and power predictor.
module modular_exponentiation_unit_tb;
    import mexp_pkg::*;

    localparam int          EXP_BITS = 63;
    localparam logic [29:0] BASE_MAX = 30'h3FFF_FFFF;
    localparam logic [62:0] EXP_MAX  = {63{1'b1}};

    // One input item: base in the low bits, exponent above it
    typedef struct packed {
        logic [62:0] exponent;
        logic [29:0] base;
    } power_job_t;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [95:0] s_tdata  = '0;     // [29:0] base, [92:30] exponent, [95:93] zero
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [31:0] m_tdata;           // [29:0] power, [31:30] zero

    power_job_t  job_queue[$];
    logic [29:0] expected_powers[$];
    int          error_count    = 0;
    int          results_seen   = 0;
    int          jobs_sent      = 0;
    int          jobs_taken     = 0;
    int          send_gap       = 0;
    int          send_idle_rate = 0;
    int          recv_gap       = 0;
    int          recv_idle_rate = 0;
    int          rate_timer     = 0;
    bit          drain_pending  = 1'b0;
    bit          long_hold_done = 1'b0;
    bit          quiet_tail     = 1'b0;

    modular_exponentiation_unit #(
        .EXP_BITS(EXP_BITS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    always #10 i_clk = ~i_clk;

    // Square-and-multiply from the top exponent bit, every product reduced mod the prime
    function automatic logic [29:0] mod_pow(logic [29:0] base, logic [62:0] exponent);
        longint unsigned prime;
        longint unsigned b;
        longint unsigned acc;
        prime = longint'(PrimeMod);
        b     = longint'(base) % prime;
        acc   = 1;
        for (int i = EXP_BITS - 1; i >= 0; i--) begin
            acc = (acc * acc) % prime;
            if (exponent[i]) begin
                acc = (acc * b) % prime;
            end
        end
        return acc[29:0];
    endfunction

    function automatic void add_job(logic [29:0] base, logic [62:0] exponent);
        power_job_t job;
        job.base     = base;
        job.exponent = exponent;
        job_queue    = {job_queue, job};
    endfunction

    // Driver: holds each item until taken, random gaps between items
    always @(negedge i_clk) begin : send_items
        logic        next_valid;
        logic [95:0] next_data;
        power_job_t  job;
        next_valid = s_tvalid;
        next_data  = s_tdata;
        if (i_rst_n && (!s_tvalid || jobs_taken == jobs_sent)) begin
            next_valid = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
            end else if (drain_pending) begin
                // pause until every result so far has come back
                if (expected_powers.size() == 0) drain_pending = 1'b0;
            end else if (job_queue.size() != 0) begin
                if (!quiet_tail && $urandom_range(0, 15) < send_idle_rate) begin
                    send_gap = $urandom_range(0, 16);
                end else begin
                    job        = job_queue.pop_front();
                    next_valid = 1'b1;
                    next_data  = {3'b000, job};
                    jobs_sent++;
                    if (jobs_sent % 40 == 0) send_idle_rate = $urandom_range(0, 3);
                    if (jobs_sent == 300) drain_pending = 1'b1;
                end
            end
        end
        s_tvalid <= next_valid;
        s_tdata  <= next_data;
    end

    // Receiver: random stall bursts, one long hold-off to back up the block
    always @(negedge i_clk) begin
        if (rate_timer == 0) begin
            recv_idle_rate = $urandom_range(0, 3);
            rate_timer     = 500;
        end else begin
            rate_timer--;
        end
        if (!long_hold_done && results_seen >= 150) begin
            long_hold_done = 1'b1;
            recv_gap       = 2000;
        end else if (recv_gap == 0 && !quiet_tail && $urandom_range(0, 63) < recv_idle_rate) begin
            recv_gap = $urandom_range(1, 17);
        end
        if (recv_gap > 0) begin
            recv_gap--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Monitor: predict on accepted input items, check accepted results in order
    always @(posedge i_clk) begin : watch_ports
        power_job_t  job;
        logic [29:0] want;
        quiet_tail = job_queue.size() < 50;
        if (i_rst_n) begin
            if (s_tvalid && s_tready) begin
                job             = s_tdata[92:0];
                expected_powers = {expected_powers, mod_pow(job.base, job.exponent)};
                jobs_taken++;
            end
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (expected_powers.size() == 0) begin
                    $error("power: no item pending, actual %0d", m_tdata[29:0]);
                    error_count++;
                end else begin
                    want = expected_powers.pop_front();
                    if (m_tdata[29:0] !== want) begin
                        $error("power: expected %0d, actual %0d", want, m_tdata[29:0]);
                        error_count++;
                    end
                end
            end
        end
    end

    // Stimulus and end of run
    initial begin
        logic [63:0] wide;
        logic [62:0] exponent;
        logic [29:0] base;

        // directed: field extremes and the special cases
        add_job(30'd0, 63'd0);                       // zero to the zero gives one
        add_job(BASE_MAX, 63'd0);
        add_job(30'd0, 63'd1);
        add_job(30'd0, EXP_MAX);
        add_job(30'd1, EXP_MAX);
        add_job(PrimeMod - 30'd1, 63'd1);
        add_job(PrimeMod - 30'd1, 63'd2);
        add_job(PrimeMod - 30'd1, EXP_MAX);
        add_job(PrimeMod, 63'd3);                    // base equal to the modulus
        add_job(PrimeMod + 30'd1, 63'd7);            // base just above the modulus
        add_job(BASE_MAX, 63'd5);
        add_job(BASE_MAX, EXP_MAX);
        add_job(30'd2, 63'd62);
        add_job(30'd2, 63'h4000_0000_0000_0000);     // top exponent bit only
        add_job(30'd3, 63'h5555_5555_5555_5555);
        add_job(30'd3, 63'h2AAA_AAAA_AAAA_AAAA);
        add_job(30'd12345, 63'd1000000006);          // Fermat: result is one
        add_job(30'h2AAA_AAAA, 63'h1555_5555_5555_5555);
        add_job(30'h1555_5555, EXP_MAX);

        // random part
        repeat (600) begin
            case ($urandom_range(0, 7))
                0:       base = ($urandom_range(0, 2) == 0) ? 30'd0 :
                                ($urandom_range(0, 1) == 0) ? 30'd1 : PrimeMod - 30'd1;
                1:       base = 30'($urandom_range(PrimeMod, BASE_MAX));
                default: base = 30'($urandom_range(0, PrimeMod - 1));
            endcase
            wide = {$urandom(), $urandom()};
            case ($urandom_range(0, 4))
                0: exponent = wide[62:0];
                1: exponent = 63'($urandom_range(0, 1000));
                2: begin
                    exponent = '0;
                    repeat ($urandom_range(1, 3)) exponent[$urandom_range(0, 62)] = 1'b1;
                end
                3: begin
                    exponent = EXP_MAX;
                    repeat ($urandom_range(1, 3)) exponent[$urandom_range(0, 62)] = 1'b0;
                end
                default: exponent = {31'd0, $urandom()};
            endcase
            add_job(base, exponent);
        end

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (job_queue.size() != 0 || s_tvalid) @(posedge i_clk);
        while (expected_powers.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(64'd40_000_000);
        $display("Some tests failed");
        $finish;
    end

endmodule
